[rtl/atn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn_pkg: shared types, constants and helpers of the text normaliser
// Request payloads, the bundle passed from front to back, register indexes
// and the ASCII character classes.
// ----------------------------------------------------------------------------
package atn_pkg;

	// Default text length width
	localparam int MAX_TEXT_BITS_DEF = 20;

	// Fixed field widths
	localparam int CHAR_W     = 8;
	localparam int FINAL_W    = 21;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	// Depth of the queue between front and back
	localparam int FIFO_DEPTH = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COMMENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLUS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 3'd5;

	// Register reset values
	localparam logic [CHAR_W-1:0] RST_COMMENT = 8'd59;
	localparam logic [CHAR_W-1:0] RST_SEP     = 8'd32;
	localparam logic [CHAR_W-1:0] RST_OPEN    = 8'd91;
	localparam logic [CHAR_W-1:0] RST_CLOSE   = 8'd93;
	localparam logic [CHAR_W-1:0] RST_PLUS    = 8'd43;

	// Character constants
	localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_DASH = 8'h2D;

	// Output slots of one bundle, in emission order
	localparam int NSLOT = 6;
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_DOT     = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_LEAD    = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_CHAR    = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_TRAIL   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_END_SEP = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_NUL     = 3'd5;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic              text_last;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  out_byte;
		logic               run_last;
		logic               text_end;
		logic [FINAL_W-1:0] final_count;
	} out_item_t;

	// Everything one input request produces, as a slot mask plus payload
	typedef struct packed {
		logic [NSLOT-1:0]   mask;
		logic [CHAR_W-1:0]  ch;
		logic [CHAR_W-1:0]  sep;
		logic [FINAL_W-1:0] final_count;
	} bundle_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

endpackage

[rtl/atn_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn_fifo: short bundle queue between front and back
// Small register queue; the front writes one bundle, the back reads one.
// ----------------------------------------------------------------------------
module atn_fifo #(
	parameter int DEPTH = atn_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  atn_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output atn_pkg::bundle_t rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	atn_pkg::bundle_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   fill_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (fill_q == CNT_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming bundle
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/atn_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn_front: character classifier and text state
// Holds the configuration registers and the running text state, classifies
// each character and turns it into at most one bundle of output slots.
// ----------------------------------------------------------------------------
module atn_front #(
	parameter int MAX_TEXT_BITS = atn_pkg::MAX_TEXT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [atn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [atn_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input requests
	input  logic                            accept,
	input  atn_pkg::in_item_t               item,
	// bundles towards the queue
	output logic                            bundle_valid,
	output atn_pkg::bundle_t                bundle
);

	localparam int CW = MAX_TEXT_BITS + 1;
	localparam int LW = (MAX_TEXT_BITS < atn_pkg::CFG_DATA_W) ?
		MAX_TEXT_BITS : atn_pkg::CFG_DATA_W;

	// Configuration registers
	logic [atn_pkg::CHAR_W-1:0] comment_q, sep_q, open_q, close_q, plus_q;
	logic [LW-1:0]              text_len_q;

	// Text state
	logic                       in_comment_q, after_space_q, seen_q, wrote_q, pend_q;
	logic [atn_pkg::CHAR_W-1:0] prev_q;
	logic [CW-1:0]              count_q;

	// Next state
	logic                       in_comment_d, after_space_d, pend_d;
	logic                       wrote_d;
	logic [atn_pkg::CHAR_W-1:0] prev_d;
	logic [CW-1:0]              count_d;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comment_q  <= atn_pkg::RST_COMMENT;
			sep_q      <= atn_pkg::RST_SEP;
			open_q     <= atn_pkg::RST_OPEN;
			close_q    <= atn_pkg::RST_CLOSE;
			plus_q     <= atn_pkg::RST_PLUS;
			text_len_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				atn_pkg::CFG_COMMENT: comment_q  <= cfg_data[atn_pkg::CHAR_W-1:0];
				atn_pkg::CFG_SEP:     sep_q      <= cfg_data[atn_pkg::CHAR_W-1:0];
				atn_pkg::CFG_OPEN:    open_q     <= cfg_data[atn_pkg::CHAR_W-1:0];
				atn_pkg::CFG_CLOSE:   close_q    <= cfg_data[atn_pkg::CHAR_W-1:0];
				atn_pkg::CFG_PLUS:    plus_q     <= cfg_data[atn_pkg::CHAR_W-1:0];
				atn_pkg::CFG_LENGTH:  text_len_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// Classify the character and build its bundle
	always_comb begin
		logic [atn_pkg::CHAR_W-1:0] c;
		logic                       dot_emit, wrote1, after1;
		logic [atn_pkg::CHAR_W-1:0] prev1;
		logic                       is_sym, is_ws, is_tok, nl_sep, ws_sep, lead_sep;
		logic                       prev_sep2, need_sep;
		logic [2:0]                 incs;
		logic [CW:0]                sum;
		logic [CW-1:0]              count_sat;
		logic [CW+atn_pkg::FINAL_W-1:0] count_ext;

		c = item.in_char;

		// Held dot is kept only before a digit
		dot_emit = pend_q && atn_pkg::is_digit(c);
		wrote1   = wrote_q || dot_emit;
		prev1    = dot_emit ? atn_pkg::CH_DOT : prev_q;
		after1   = dot_emit ? 1'b0 : after_space_q;

		is_ws  = (c == sep_q) || atn_pkg::is_space(c);
		is_sym = (c == open_q) || (c == close_q) || (c == plus_q);
		is_tok = atn_pkg::is_alnum(c) || (c == atn_pkg::CH_DASH);

		nl_sep   = 1'b0;
		ws_sep   = 1'b0;
		lead_sep = 1'b0;
		in_comment_d = in_comment_q;
		after_space_d = after1;
		pend_d = 1'b0;
		bundle.mask = '0;
		incs = {2'b00, dot_emit};

		// Priority: comment, separator or whitespace, symbols, tokens, dot
		if (in_comment_q) begin
			if (c == atn_pkg::CH_NL) begin
				nl_sep = wrote1 && atn_pkg::is_alnum(prev1);
				if (nl_sep) begin
					after_space_d = 1'b1;
				end
				in_comment_d = 1'b0;
			end
		end else if (c == comment_q) begin
			in_comment_d = 1'b1;
		end else if (is_ws) begin
			ws_sep = !after1;
			after_space_d = 1'b1;
			incs = incs + {2'b00, ws_sep};
		end else if (is_sym) begin
			lead_sep = seen_q && !(wrote1 && (prev1 == sep_q));
			bundle.mask[atn_pkg::SLOT_CHAR]  = 1'b1;
			bundle.mask[atn_pkg::SLOT_TRAIL] = 1'b1;
			after_space_d = 1'b1;
			incs = incs + {2'b00, lead_sep} + 3'd2;
		end else if (is_tok) begin
			bundle.mask[atn_pkg::SLOT_CHAR] = 1'b1;
			after_space_d = 1'b0;
			incs = incs + 3'd1;
		end else if (c == atn_pkg::CH_DOT) begin
			pend_d = (count_q != '0) && (count_q < CW'(text_len_q)) &&
				((wrote1 && (prev1 == sep_q)) ||
				 (wrote1 && atn_pkg::is_digit(prev1)));
		end

		bundle.mask[atn_pkg::SLOT_DOT]  = dot_emit;
		bundle.mask[atn_pkg::SLOT_LEAD] = nl_sep || ws_sep || lead_sep;

		// Last written byte after this character
		wrote_d = wrote1 || bundle.mask[atn_pkg::SLOT_LEAD] ||
			bundle.mask[atn_pkg::SLOT_CHAR];
		if (bundle.mask[atn_pkg::SLOT_TRAIL]) begin
			prev_d = sep_q;
		end else if (bundle.mask[atn_pkg::SLOT_CHAR]) begin
			prev_d = c;
		end else if (bundle.mask[atn_pkg::SLOT_LEAD]) begin
			prev_d = sep_q;
		end else begin
			prev_d = prev1;
		end

		// Close the text: optional separator, then the NUL
		prev_sep2 = wrote_d && (prev_d == sep_q);
		need_sep  = !prev_sep2;
		if (item.text_last) begin
			bundle.mask[atn_pkg::SLOT_END_SEP] = need_sep;
			bundle.mask[atn_pkg::SLOT_NUL]     = 1'b1;
			incs = incs + {2'b00, need_sep} + 3'd1;
		end

		// Saturating count update
		sum = {1'b0, count_q} + (CW+1)'(incs);
		count_sat = sum[CW] ? '1 : sum[CW-1:0];
		count_d = count_sat;

		count_ext = {{atn_pkg::FINAL_W{1'b0}}, count_sat};
		bundle.ch  = c;
		bundle.sep = sep_q;
		bundle.final_count = count_ext[atn_pkg::FINAL_W-1:0];
		bundle_valid = accept && (bundle.mask != '0);
	end

	// Advance text state; clear it after the end of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q  <= 1'b0;
			after_space_q <= 1'b0;
			seen_q        <= 1'b0;
			wrote_q       <= 1'b0;
			pend_q        <= 1'b0;
			prev_q        <= '0;
			count_q       <= '0;
		end else if (accept) begin
			if (item.text_last) begin
				in_comment_q  <= 1'b0;
				after_space_q <= 1'b0;
				seen_q        <= 1'b0;
				wrote_q       <= 1'b0;
				pend_q        <= 1'b0;
				prev_q        <= '0;
				count_q       <= '0;
			end else begin
				in_comment_q  <= in_comment_d;
				after_space_q <= after_space_d;
				seen_q        <= 1'b1;
				wrote_q       <= wrote_d;
				pend_q        <= pend_d;
				prev_q        <= prev_d;
				count_q       <= count_d;
			end
		end
	end

endmodule

[rtl/atn_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn_back: bundle unpacker and result register
// Takes bundles from the queue and emits their slots one byte per cycle, while the result
// register is empty or being popped, into the result register.
// ----------------------------------------------------------------------------
module atn_back (
	input  logic               clk,
	input  logic               arst_n,
	// queue side
	input  logic               q_empty,
	input  atn_pkg::bundle_t   q_data,
	output logic               q_pop,
	// result side
	output logic               empty,
	input  logic               pop,
	output atn_pkg::out_item_t result
);

	atn_pkg::bundle_t           cur_q;
	atn_pkg::out_item_t         out_q;
	logic                       out_valid_q;

	logic                       adv, cur_has, emit, need_load;
	logic [atn_pkg::NSLOT-1:0]  sel_oh, rem;
	logic [atn_pkg::SLOT_W-1:0] sel;
	atn_pkg::out_item_t         nxt;

	assign adv     = !out_valid_q || pop;
	assign cur_has = (cur_q.mask != '0);
	assign emit    = adv && cur_has;

	// Pick the earliest remaining slot
	always_comb begin
		sel    = '0;
		sel_oh = '0;
		for (int i = atn_pkg::NSLOT - 1; i >= 0; i--) begin
			if (cur_q.mask[i]) begin
				sel    = atn_pkg::SLOT_W'(i);
				sel_oh = atn_pkg::NSLOT'(1) << i;
			end
		end
		rem = cur_q.mask & ~sel_oh;
	end

	// Form the result for the chosen slot
	always_comb begin
		nxt.run_last    = (rem == '0);
		nxt.text_end    = 1'b0;
		nxt.final_count = '0;
		case (sel)
			atn_pkg::SLOT_DOT:  nxt.out_byte = atn_pkg::CH_DOT;
			atn_pkg::SLOT_CHAR: nxt.out_byte = cur_q.ch;
			atn_pkg::SLOT_NUL: begin
				nxt.out_byte    = atn_pkg::CH_NUL;
				nxt.text_end    = 1'b1;
				nxt.final_count = cur_q.final_count;
			end
			default:            nxt.out_byte = cur_q.sep;
		endcase
	end

	assign need_load = !cur_has || (emit && (rem == '0));
	assign q_pop     = need_load && !q_empty;

	// Load the next bundle or drop the emitted slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (q_pop) begin
			cur_q <= q_data;
		end else if (emit) begin
			cur_q.mask <= rem;
		end
	end

	// Hold the result until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= cur_has;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nxt;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

[rtl/assembly_text_normalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembly_text_normalizer: assembly source text normaliser, top level
// A character's first result is ready once its bundle has passed the queue and the back's
// current-bundle register into the result register. Throughput: one character per cycle
// while the four-entry bundle queue has room; results leave one per cycle while popped.
// Reset clears text state, queue and result register and restores register defaults.
// ----------------------------------------------------------------------------
module assembly_text_normalizer #(
	parameter int MAX_TEXT_BITS = atn_pkg::MAX_TEXT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [atn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [atn_pkg::CFG_DATA_W-1:0] cfg_data,
	// character requests
	input  logic                           push,
	output logic                           full,
	input  atn_pkg::in_item_t              item,
	// result requests
	output logic                           empty,
	input  logic                           pop,
	output atn_pkg::out_item_t             result
);

	logic             accept;
	logic             bundle_valid;
	atn_pkg::bundle_t bundle;
	logic             q_full, q_empty, q_pop;
	atn_pkg::bundle_t q_data;

	// Take a character whenever the queue has room
	assign full   = q_full;
	assign accept = push && !q_full;

	atn_front #(
		.MAX_TEXT_BITS(MAX_TEXT_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.accept       (accept),
		.item         (item),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	atn_fifo #(
		.DEPTH(atn_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (bundle_valid),
		.wr_data (bundle),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	atn_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
